// File: rtl/core/token_detokenize_byte_gather_macros.svh
// Assertion macros of the detokenizer RTL.
`ifndef TOKEN_DETOKENIZE_BYTE_GATHER_MACROS_SVH
`define TOKEN_DETOKENIZE_BYTE_GATHER_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define TDBG_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("tdbg assertion failed");

// Next-cycle implication, disabled during reset.
`define TDBG_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("tdbg assertion failed");

`endif

// File: rtl/core/tdbg_pkg.sv
// Types and constants of the token detokenizer byte gather block.
package tdbg_pkg;

   localparam int VOCAB_DEPTH       = 262144;
   localparam int PIECE_STORE_BYTES = 1048576;   // a power of two
   localparam int MAX_PIECE_BYTES   = 64;

   localparam int VOCAB_AW  = $clog2(VOCAB_DEPTH);
   localparam int PIECE_AW  = $clog2(PIECE_STORE_BYTES);
   localparam int VSIZE_W   = 19;
   localparam int SIZE_W    = 7;
   localparam int OFFSET_W  = 20;

   typedef enum logic [1:0] {
      KIND_LOAD_ENTRY = 2'd0,
      KIND_LOAD_BYTE  = 2'd1,
      KIND_TOKEN      = 2'd2,
      KIND_END_SEQ    = 2'd3
   } req_kind_type;

   localparam logic OUT_KIND_BYTE    = 1'b0;
   localparam logic OUT_KIND_SUMMARY = 1'b1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_LOOKUP,
      ST_GATHER,
      ST_SUMMARY
   } state_type;

   typedef struct packed {
      req_kind_type       kind;
      logic signed [31:0] tok_id;
      logic [17:0]        entry_index;
      logic [19:0]        entry_offset;
      logic [6:0]         entry_size;
      logic [19:0]        piece_addr;
      logic [7:0]         piece_byte;
   } req_type;

   typedef struct packed {
      logic        out_kind;
      logic [7:0]  byte_value;
      logic [31:0] byte_position;
      logic [31:0] seq_length;
      logic [31:0] seq_end_offset;
      logic        last;
   } rsp_type;

   typedef struct packed {
      logic [OFFSET_W-1:0] offset;
      logic [SIZE_W-1:0]   size;
   } vocab_entry_type;

   typedef struct packed {
      logic                 wr_en;
      logic [VOCAB_AW-1:0]  wr_addr;
      vocab_entry_type      wr_data;
      logic                 rd_en;
      logic [VOCAB_AW-1:0]  rd_addr;
   } vocab_port_type;

   typedef struct packed {
      logic                 wr_en;
      logic [PIECE_AW-1:0]  wr_addr;
      logic [7:0]           wr_data;
      logic                 rd_en;
      logic [PIECE_AW-1:0]  rd_addr;
   } piece_port_type;

endpackage

// File: rtl/core/tdbg_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
module tdbg_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64,
   localparam int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // The read register holds its value while no read is issued.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/core/tdbg_ctrl.sv
// Sequencer of the detokenizer: item decode, table lookup, byte gather and cursor.
`include "token_detokenize_byte_gather_macros.svh"

module tdbg_ctrl (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  tdbg_pkg::req_type         req_data,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output tdbg_pkg::rsp_type         rsp_data,
   input  logic                      csr_wr_en,
   input  logic [tdbg_pkg::VSIZE_W-1:0] csr_wr_data,
   output tdbg_pkg::vocab_port_type  vocab_port,
   input  tdbg_pkg::vocab_entry_type vocab_rd_data,
   output tdbg_pkg::piece_port_type  piece_port,
   input  logic [7:0]                piece_rd_data
);

   tdbg_pkg::state_type state_ff, state_in;

   logic [tdbg_pkg::VSIZE_W-1:0]  vocab_size_ff;
   logic [31:0]                   cursor_ff;
   logic [31:0]                   seq_start_ff;
   logic [tdbg_pkg::PIECE_AW-1:0] addr_ff;
   logic [tdbg_pkg::SIZE_W-1:0]   remain_ff;

   logic        rsp_valid_ff;
   logic        rsp_kind_ff;
   logic [31:0] rsp_pos_ff;
   logic [31:0] rsp_len_ff;
   logic [31:0] rsp_end_ff;
   logic        rsp_last_ff;

   logic req_fire, slot_free, byte_load, sum_load;
   logic tid_ok, eidx_ok, paddr_ok;
   logic [31:0] tid_u, eidx_32, paddr_32, voff_32;
   logic [tdbg_pkg::SIZE_W-1:0] esz_clamped, vsz_clamped;

   assign req_fire  = req_valid && req_ready;
   assign slot_free = !rsp_valid_ff || rsp_ready;

   assign tid_u    = req_data.tok_id;
   assign eidx_32  = {14'd0, req_data.entry_index};
   assign paddr_32 = {12'd0, req_data.piece_addr};
   assign voff_32  = {12'd0, vocab_rd_data.offset};

   assign tid_ok   = (tid_u < {13'd0, vocab_size_ff}) && (tid_u < 32'(tdbg_pkg::VOCAB_DEPTH));
   assign eidx_ok  = eidx_32 < 32'(tdbg_pkg::VOCAB_DEPTH);
   assign paddr_ok = paddr_32 < 32'(tdbg_pkg::PIECE_STORE_BYTES);

   assign esz_clamped = (req_data.entry_size > tdbg_pkg::SIZE_W'(tdbg_pkg::MAX_PIECE_BYTES)) ?
                        tdbg_pkg::SIZE_W'(tdbg_pkg::MAX_PIECE_BYTES) : req_data.entry_size;
   assign vsz_clamped = (vocab_rd_data.size > tdbg_pkg::SIZE_W'(tdbg_pkg::MAX_PIECE_BYTES)) ?
                        tdbg_pkg::SIZE_W'(tdbg_pkg::MAX_PIECE_BYTES) : vocab_rd_data.size;

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         tdbg_pkg::ST_IDLE: begin
            if (req_fire && req_data.kind == tdbg_pkg::KIND_TOKEN && tid_ok) begin
               state_in = tdbg_pkg::ST_LOOKUP;
            end else if (req_fire && req_data.kind == tdbg_pkg::KIND_END_SEQ) begin
               state_in = tdbg_pkg::ST_SUMMARY;
            end
         end
         tdbg_pkg::ST_LOOKUP: begin
            state_in = (vsz_clamped != '0) ? tdbg_pkg::ST_GATHER : tdbg_pkg::ST_IDLE;
         end
         tdbg_pkg::ST_GATHER: begin
            if (slot_free && remain_ff == tdbg_pkg::SIZE_W'(1)) begin
               state_in = tdbg_pkg::ST_IDLE;
            end
         end
         tdbg_pkg::ST_SUMMARY: begin
            if (slot_free) begin
               state_in = tdbg_pkg::ST_IDLE;
            end
         end
         default: state_in = tdbg_pkg::ST_IDLE;
      endcase
   end

   // Outputs of the sequencer.
   always_comb begin
      req_ready                = 1'b0;
      byte_load                = 1'b0;
      sum_load                 = 1'b0;
      vocab_port.wr_en         = 1'b0;
      vocab_port.rd_en         = 1'b0;
      piece_port.wr_en         = 1'b0;
      piece_port.rd_en         = 1'b0;
      vocab_port.wr_addr       = eidx_32[tdbg_pkg::VOCAB_AW-1:0];
      vocab_port.wr_data.offset = req_data.entry_offset;
      vocab_port.wr_data.size  = esz_clamped;
      vocab_port.rd_addr       = tid_u[tdbg_pkg::VOCAB_AW-1:0];
      piece_port.wr_addr       = paddr_32[tdbg_pkg::PIECE_AW-1:0];
      piece_port.wr_data       = req_data.piece_byte;
      piece_port.rd_addr       = addr_ff;
      case (state_ff)
         tdbg_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            vocab_port.wr_en = req_fire && req_data.kind == tdbg_pkg::KIND_LOAD_ENTRY && eidx_ok;
            vocab_port.rd_en = req_fire && req_data.kind == tdbg_pkg::KIND_TOKEN && tid_ok;
            piece_port.wr_en = req_fire && req_data.kind == tdbg_pkg::KIND_LOAD_BYTE && paddr_ok;
         end
         tdbg_pkg::ST_GATHER: begin
            byte_load        = slot_free;
            piece_port.rd_en = slot_free;
         end
         tdbg_pkg::ST_SUMMARY: begin
            sum_load = slot_free;
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= tdbg_pkg::ST_IDLE;
         vocab_size_ff <= '0;
         cursor_ff     <= '0;
         seq_start_ff  <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_wr_en) begin
            vocab_size_ff <= csr_wr_data;
         end
         if (byte_load) begin
            cursor_ff <= cursor_ff + 32'd1;
         end
         if (sum_load) begin
            seq_start_ff <= cursor_ff;
         end
         if (byte_load || sum_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (state_ff == tdbg_pkg::ST_LOOKUP) begin
         addr_ff   <= voff_32[tdbg_pkg::PIECE_AW-1:0];
         remain_ff <= vsz_clamped;
      end else if (byte_load) begin
         addr_ff   <= addr_ff + tdbg_pkg::PIECE_AW'(1);
         remain_ff <= remain_ff - tdbg_pkg::SIZE_W'(1);
      end
      if (byte_load) begin
         rsp_kind_ff <= tdbg_pkg::OUT_KIND_BYTE;
         rsp_pos_ff  <= cursor_ff;
         rsp_len_ff  <= '0;
         rsp_end_ff  <= '0;
         rsp_last_ff <= (remain_ff == tdbg_pkg::SIZE_W'(1));
      end else if (sum_load) begin
         rsp_kind_ff <= tdbg_pkg::OUT_KIND_SUMMARY;
         rsp_pos_ff  <= '0;
         rsp_len_ff  <= cursor_ff - seq_start_ff;
         rsp_end_ff  <= cursor_ff;
         rsp_last_ff <= 1'b1;
      end
   end

   // The byte itself sits in the piece memory's read register.
   assign rsp_valid               = rsp_valid_ff;
   assign rsp_data.out_kind       = rsp_kind_ff;
   assign rsp_data.byte_value     = (rsp_kind_ff == tdbg_pkg::OUT_KIND_BYTE) ? piece_rd_data : 8'd0;
   assign rsp_data.byte_position  = rsp_pos_ff;
   assign rsp_data.seq_length     = rsp_len_ff;
   assign rsp_data.seq_end_offset = rsp_end_ff;
   assign rsp_data.last           = rsp_last_ff;

   `TDBG_ASSERT_NOW(a_gather_count, clock, reset, state_ff == tdbg_pkg::ST_GATHER, remain_ff != '0)
   `TDBG_ASSERT_NOW(a_no_rw_clash, clock, reset, vocab_port.rd_en, !vocab_port.wr_en)
   `TDBG_ASSERT_NOW(a_lookup_src, clock, reset, state_in == tdbg_pkg::ST_LOOKUP, vocab_port.rd_en)
   `TDBG_ASSERT_NEXT(a_summary_mark, clock, reset, sum_load, seq_start_ff == cursor_ff)

endmodule

// File: rtl/core/token_detokenize_byte_gather.sv
// Top level of the token detokenizer byte gather block.
//
// Input items arrive on the req_ channel (valid/ready) and are taken only while
// the sequencer is idle. Entry and byte loads write the vocabulary table or the
// piece store and finish in the cycle of their transfer; they produce nothing.
// A token transfer reads its vocabulary entry, passes the lookup and gather
// states, and offers its piece bytes on the rsp_ channel through the output
// register. The bytes follow at one per cycle while the receiver takes them;
// the piece store read port sets this rate. An out-of-range token leaves the
// sequencer idle, and a token with an empty piece returns to idle after the
// lookup. An end-of-sequence item gives one summary result through the summary
// state and the output register. When the receiver stalls, the result holds in
// the output register and in the piece memory's read register, and the gather
// pauses until it is taken. Synchronous reset clears vocab_size, the cursor and
// the sequence start and empties the output; the two memories are not cleared
// and must be loaded before use. The user must write vocab_size through
// csr_wr_en and csr_wr_data while the block is idle; it does not enforce this.
module token_detokenize_byte_gather (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  tdbg_pkg::req_type            req_data,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output tdbg_pkg::rsp_type            rsp_data,
   input  logic                         csr_wr_en,
   input  logic [tdbg_pkg::VSIZE_W-1:0] csr_wr_data
);

   tdbg_pkg::vocab_port_type  vocab_port;
   tdbg_pkg::piece_port_type  piece_port;
   tdbg_pkg::vocab_entry_type vocab_rd_data;
   logic [$bits(tdbg_pkg::vocab_entry_type)-1:0] vocab_rd_raw;
   logic [7:0] piece_rd_data;

   // The sequencer owns the cursor, the lookup and the output register.
   tdbg_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_data      (req_data),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_data      (rsp_data),
      .csr_wr_en     (csr_wr_en),
      .csr_wr_data   (csr_wr_data),
      .vocab_port    (vocab_port),
      .vocab_rd_data (vocab_rd_data),
      .piece_port    (piece_port),
      .piece_rd_data (piece_rd_data)
   );

   // Vocabulary table: offset and size of each entry side by side in one word.
   tdbg_ram #(
      .WIDTH ($bits(tdbg_pkg::vocab_entry_type)),
      .DEPTH (tdbg_pkg::VOCAB_DEPTH)
   ) u_vocab_ram (
      .clock   (clock),
      .wr_en   (vocab_port.wr_en),
      .wr_addr (vocab_port.wr_addr),
      .wr_data (vocab_port.wr_data),
      .rd_en   (vocab_port.rd_en),
      .rd_addr (vocab_port.rd_addr),
      .rd_data (vocab_rd_raw)
   );

   assign vocab_rd_data = tdbg_pkg::vocab_entry_type'(vocab_rd_raw);

   // Piece byte store.
   tdbg_ram #(
      .WIDTH (8),
      .DEPTH (tdbg_pkg::PIECE_STORE_BYTES)
   ) u_piece_ram (
      .clock   (clock),
      .wr_en   (piece_port.wr_en),
      .wr_addr (piece_port.wr_addr),
      .wr_data (piece_port.wr_data),
      .rd_en   (piece_port.rd_en),
      .rd_addr (piece_port.rd_addr),
      .rd_data (piece_rd_data)
   );

endmodule

// File: tb/sv/token_detokenize_byte_gather_tb.sv
// Self-checking testbench for the token detokenizer byte gather block.
module token_detokenize_byte_gather_tb;
   import tdbg_pkg::*;

   // A short settling pause covers an item that produced nothing but may still
   // be in the sequencer.
   localparam int unsigned SETTLE_CYCLES = 8;
   // Slowest correct run: every item of up to 64 bytes, with every byte waiting
   // out the longest receiver stall, plus the long hold-off. Taken well over.
   localparam int unsigned CYCLE_LIMIT = 1_000_000;
   localparam int unsigned HOLD_OFF_CYCLES = 300;

   logic                clock       = 1'b0;
   logic                reset       = 1'b1;
   logic                req_valid   = 1'b0;
   logic                req_ready;
   req_type             req_data    = '0;
   logic                rsp_valid;
   logic                rsp_ready   = 1'b0;
   rsp_type             rsp_data;
   logic                csr_wr_en   = 1'b0;
   logic [VSIZE_W-1:0]  csr_wr_data = '0;

   // Own copy of the block's state, updated as each transfer is accepted.
   int unsigned         vocab_limit = 0;
   int unsigned         entry_offset_of[int unsigned];
   int unsigned         entry_length_of[int unsigned];
   bit [7:0]            piece_mem[int unsigned];
   bit [31:0]           byte_cursor = '0;
   bit [31:0]           seq_begin   = '0;
   int unsigned         loaded_ids[$];

   // Output items the block owes us, oldest first.
   rsp_type             gathered_out_q[$];

   int unsigned         mismatch_count  = 0;
   int unsigned         outputs_seen    = 0;
   int unsigned         items_sent      = 0;
   int unsigned         cycle_count     = 0;
   int unsigned         rsp_hold_cycles = 0;
   bit                  req_gaps_on     = 1'b1;
   bit                  rsp_stalls_on   = 1'b1;

   token_detokenize_byte_gather DUT (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_data    (rsp_data),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Watchdog: a hang anywhere ends the run as a failure.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end
   end

   task automatic report_mismatch(input string what);
      $display("%0t: %s", $time, what);
      mismatch_count++;
   endtask

   task automatic check_field(input string name, input logic [31:0] got,
                              input logic [31:0] want);
      if (got !== want)
         report_mismatch($sformatf("result %0d, %s: got %0h, expected %0h",
                                   outputs_seen, name, got, want));
   endtask

   function automatic bit id_in_range(input bit [31:0] id);
      // A negative id seen unsigned is at least 2^31, so it fails both tests.
      return (id < vocab_limit) && (id < 32'(VOCAB_DEPTH));
   endfunction

   // True when a token with this id would only touch entries and bytes that
   // have been loaded; the memories are not cleared at reset.
   function automatic bit entry_readable(input bit [31:0] id);
      if (!entry_offset_of.exists(id))
         return 1'b0;
      for (int unsigned i = 0; i < entry_length_of[id]; i++)
         if (!piece_mem.exists((entry_offset_of[id] + i) % PIECE_STORE_BYTES))
            return 1'b0;
      return 1'b1;
   endfunction

   // Applies one accepted item to the state copy and queues the output items
   // that it causes.
   function automatic void gather_item(input req_type item);
      rsp_type     r;
      bit [31:0]   id;
      int unsigned len;
      int unsigned off;
      case (item.kind)
         KIND_LOAD_ENTRY: begin
            // Oversized entries are stored clamped to the longest piece.
            len = item.entry_size;
            if (len > MAX_PIECE_BYTES)
               len = MAX_PIECE_BYTES;
            entry_offset_of[item.entry_index] = item.entry_offset;
            entry_length_of[item.entry_index] = len;
            loaded_ids.push_back(item.entry_index);
         end
         KIND_LOAD_BYTE: begin
            piece_mem[item.piece_addr] = item.piece_byte;
         end
         KIND_TOKEN: begin
            id = item.tok_id;
            if (id_in_range(id)) begin
               off = entry_offset_of[id];
               len = entry_length_of[id];
               // A piece that runs past the end of the store wraps to its start.
               for (int unsigned i = 0; i < len; i++) begin
                  r = '0;
                  r.out_kind      = OUT_KIND_BYTE;
                  r.byte_value    = piece_mem[(off + i) % PIECE_STORE_BYTES];
                  r.byte_position = byte_cursor;
                  r.last          = (i + 1 == len);
                  gathered_out_q.push_back(r);
                  byte_cursor++;
               end
            end
         end
         default: begin
            r = '0;
            r.out_kind       = OUT_KIND_SUMMARY;
            r.seq_length     = byte_cursor - seq_begin;
            r.seq_end_offset = byte_cursor;
            r.last           = 1'b1;
            gathered_out_q.push_back(r);
            seq_begin = byte_cursor;
         end
      endcase
   endfunction

   // Every result transfer is held against the oldest owed output item.
   always @(posedge clock) begin : output_checker
      rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (gathered_out_q.size() == 0) begin
            report_mismatch("result transfer with no output item owed");
         end else begin
            want = gathered_out_q.pop_front();
            check_field("out_kind", rsp_data.out_kind, want.out_kind);
            check_field("byte_value", rsp_data.byte_value, want.byte_value);
            check_field("byte_position", rsp_data.byte_position, want.byte_position);
            check_field("seq_length", rsp_data.seq_length, want.seq_length);
            check_field("seq_end_offset", rsp_data.seq_end_offset, want.seq_end_offset);
            check_field("last", rsp_data.last, want.last);
         end
         outputs_seen++;
      end
   end

   // Receiver: before each result it may hold ready low for a random number of
   // cycles. A requested hold-off is added on top, counted here, so the sender
   // carries on offering items while the block backs up.
   initial begin : result_receiver
      int unsigned wait_cycles;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         wait_cycles = rsp_stalls_on ? $urandom_range(0, 13) : 0;
         wait_cycles += rsp_hold_cycles;
         rsp_hold_cycles = 0;
         if (wait_cycles != 0) begin
            rsp_ready <= 1'b0;
            repeat (wait_cycles) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         @(posedge clock);
         while (!rsp_valid) @(posedge clock);
      end
   end

   // Offers one item after a random gap and returns at the edge of its
   // transfer. Valid is left high so that a following item with no gap goes
   // straight out; whoever lets time pass next lowers it.
   task automatic send_item(input req_type item);
      int unsigned gap;
      gap = req_gaps_on ? $urandom_range(0, 13) : 0;
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      gather_item(item);
      items_sent++;
   endtask

   // Fields that the kind does not use still carry random values.
   function automatic req_type random_req();
      req_type it;
      it.kind         = req_kind_type'($urandom_range(0, 3));
      it.tok_id       = $urandom;
      it.entry_index  = 18'($urandom);
      it.entry_offset = 20'($urandom);
      it.entry_size   = 7'($urandom);
      it.piece_addr   = 20'($urandom);
      it.piece_byte   = 8'($urandom);
      return it;
   endfunction

   task automatic load_entry(input int unsigned idx, input int unsigned off,
                             input int unsigned len);
      req_type it;
      it = random_req();
      it.kind         = KIND_LOAD_ENTRY;
      it.entry_index  = 18'(idx);
      it.entry_offset = 20'(off);
      it.entry_size   = 7'(len);
      send_item(it);
   endtask

   task automatic load_byte(input int unsigned addr, input bit [7:0] value);
      req_type it;
      it = random_req();
      it.kind       = KIND_LOAD_BYTE;
      it.piece_addr = 20'(addr);
      it.piece_byte = value;
      send_item(it);
   endtask

   task automatic send_token(input bit [31:0] id);
      req_type it;
      it = random_req();
      it.kind   = KIND_TOKEN;
      it.tok_id = id;
      send_item(it);
   endtask

   task automatic end_sequence();
      req_type it;
      it = random_req();
      it.kind = KIND_END_SEQ;
      send_item(it);
   endtask

   // Loads the bytes of a piece (those not loaded yet, and now and then an
   // old one with a fresh value), then the entry that points at them.
   task automatic define_piece(input int unsigned idx, input int unsigned off,
                               input int unsigned len);
      int unsigned n;
      int unsigned addr;
      n = (len > MAX_PIECE_BYTES) ? MAX_PIECE_BYTES : len;
      for (int unsigned i = 0; i < n; i++) begin
         addr = (off + i) % PIECE_STORE_BYTES;
         if (!piece_mem.exists(addr) || $urandom_range(0, 3) == 0)
            load_byte(addr, 8'($urandom));
      end
      load_entry(idx, off, len);
   endtask

   // Entry indices cluster low so that they are mostly in range whatever the
   // vocabulary size; the rest spread over the whole table.
   function automatic int unsigned pick_index();
      int unsigned span;
      span = (vocab_limit == 0 || vocab_limit > 24) ? 24 : vocab_limit;
      if ($urandom_range(0, 9) < 8)
         return $urandom_range(0, span - 1);
      return $urandom_range(0, VOCAB_DEPTH - 1);
   endfunction

   // Mostly ids whose piece is fully loaded; otherwise ids that are out of
   // range one way or another. An in-range id with an unloaded entry or
   // unloaded bytes is never sent.
   function automatic bit [31:0] pick_token();
      bit [31:0] id;
      if ($urandom_range(0, 99) < 80 && loaded_ids.size() != 0) begin
         for (int t = 0; t < 8; t++) begin
            id = loaded_ids[$urandom_range(0, loaded_ids.size() - 1)];
            if (id_in_range(id) && entry_readable(id))
               return id;
         end
      end
      case ($urandom_range(0, 3))
         0:       id = vocab_limit + $urandom_range(0, 3);
         1:       id = $urandom | 32'h8000_0000;
         2:       id = $urandom;
         default: id = 32'(VOCAB_DEPTH) + $urandom_range(0, 1000);
      endcase
      if (id_in_range(id) && !entry_readable(id))
         id = 32'hFFFF_FFFF;
      return id;
   endfunction

   // Lowers valid, then waits until every owed output item has arrived and a
   // little longer for any item that produced nothing.
   task automatic wait_for_outputs();
      req_valid <= 1'b0;
      @(posedge clock);
      while (gathered_out_q.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // The vocabulary size is only changed while the block is idle.
   task automatic write_vocab_size(input int unsigned value);
      wait_for_outputs();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value[VSIZE_W-1:0];
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      vocab_limit = value;
   endtask

   // With an empty vocabulary every token is out of range and nothing is read;
   // the summary reports an empty sequence.
   task automatic test_empty_vocabulary();
      write_vocab_size(0);
      send_token(0);
      send_token(32'h0003_FFFF);
      end_sequence();
   endtask

   // Short pieces with extreme byte values, a zero-size entry, a piece that
   // wraps round the end of the store, the top valid id and ids just past
   // the vocabulary, negative and far out of range, then an empty sequence.
   task automatic test_directed_cases();
      write_vocab_size(16);
      load_byte(20'h0_0010, 8'h00);
      load_byte(20'h0_0011, 8'hFF);
      load_byte(20'h0_0012, 8'h5A);
      load_byte(20'hF_FFFF, 8'hC3);
      load_byte(20'h0_0000, 8'h3C);
      load_entry(0, 20'h0_0010, 1);
      load_entry(15, 20'h0_0011, 2);
      load_entry(3, 20'h0_0012, 0);
      load_entry(7, 20'hF_FFFF, 2);
      send_token(0);
      send_token(15);
      send_token(3);
      send_token(7);
      send_token(16);
      send_token(32'hFFFF_FFFF);
      send_token(32'h8000_0000);
      send_token(32'h7FFF_FFFF);
      send_token(32'(VOCAB_DEPTH));
      end_sequence();
      end_sequence();
   endtask

   // Largest vocabulary, the last table entry, an oversized entry clamped to
   // the longest piece, and a longest piece that wraps round the store end.
   task automatic test_longest_piece();
      write_vocab_size(VOCAB_DEPTH);
      define_piece(VOCAB_DEPTH - 1, 20'hF_FFE0, 127);
      load_entry(5, 20'hF_FFE0, MAX_PIECE_BYTES);
      send_token(VOCAB_DEPTH - 1);
      send_token(5);
      end_sequence();
   endtask

   // Sequences of piece definitions, tokens and an end of sequence, with stray
   // loads, unfinished sequences and out-of-range tokens mixed in.
   task automatic test_random_traffic(input int unsigned vocab, input bit idling,
                                      input int unsigned item_goal);
      int unsigned stop_at;
      int unsigned len;
      int unsigned off;
      write_vocab_size(vocab);
      req_gaps_on   = idling;
      rsp_stalls_on = idling;
      stop_at = items_sent + item_goal;
      while (items_sent < stop_at) begin
         repeat ($urandom_range(0, 2)) begin
            case ($urandom_range(0, 19))
               0:       len = 0;
               1:       len = MAX_PIECE_BYTES;
               2:       len = $urandom_range(MAX_PIECE_BYTES + 1, 127);
               3, 4:    len = $urandom_range(9, MAX_PIECE_BYTES - 1);
               default: len = $urandom_range(1, 8);
            endcase
            // Long pieces sit where bytes are already loaded, so that they
            // cost few load items; some short ones land anywhere.
            case ($urandom_range(0, 9))
               0, 1:    off = (len > 8) ? 20'h0_0100 : 20'($urandom);
               2, 3:    off = PIECE_STORE_BYTES - $urandom_range(1, MAX_PIECE_BYTES);
               default: off = 20'h0_0100 + $urandom_range(0, 255);
            endcase
            define_piece(pick_index(), off, len);
         end
         if ($urandom_range(0, 7) == 0)
            load_byte(20'($urandom), 8'($urandom));
         if ($urandom_range(0, 9) == 0)
            load_entry(pick_index(), 20'($urandom), 7'($urandom));
         repeat ($urandom_range(1, 8)) send_token(pick_token());
         if ($urandom_range(0, 7) != 0)
            end_sequence();
      end
      req_gaps_on   = 1'b1;
      rsp_stalls_on = 1'b1;
   endtask

   // The receiver holds off for a long stretch while the sender offers tokens
   // back to back, so the output and the gather back up and the input stalls.
   // Before the burst the sender pauses until every owed item has come.
   task automatic test_full_stall();
      write_vocab_size(VOCAB_DEPTH);
      define_piece(1, 20'h0_0180, 6);
      define_piece(2, 20'h0_01A0, 9);
      wait_for_outputs();
      req_gaps_on     = 1'b0;
      rsp_hold_cycles = HOLD_OFF_CYCLES;
      send_token(2);
      send_token(1);
      repeat (10) send_token(pick_token());
      end_sequence();
      wait_for_outputs();
      req_gaps_on = 1'b1;
   endtask

   initial begin : test_sequence
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      test_empty_vocabulary();
      test_directed_cases();
      test_longest_piece();
      test_random_traffic(VOCAB_DEPTH, 1'b1, 25);
      test_full_stall();
      test_random_traffic(VOCAB_DEPTH - 1, 1'b0, 15);
      test_random_traffic($urandom_range(1, 24), 1'b1, 20);
      end_sequence();
      wait_for_outputs();
      if (mismatch_count == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
